[hw/rtl/abrq_pkg.sv]
// Shared types, constants and helpers for the acknowledged batch ring queue.
// Used by abrq_front, abrq_cmd_fifo, abrq_back and the top level.
`default_nettype none

package abrq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ENTRY_WIDTH = 64;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int LIMIT_W     = 7;
  localparam int PEND_W      = 7;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LIMIT_CAP   = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12);

  localparam int MODE_W      = 2;
  localparam int DATA_W      = 64;
  localparam int IDX_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int LEVEL_W     = 9;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_FIELD_W = DATA_W + IDX_W + PEND_W + LEVEL_W;
  localparam int OUT_TDATA_W = 88;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_ACK     = 2'd2,
    MODE_ABORT   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENTRY = 3'd0,
    ST_NONE  = 3'd1,
    ST_PUSH  = 3'd2,
    ST_DROP  = 3'd3,
    ST_ACK   = 3'd4,
    ST_BUSY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_BATCH  = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_BATCH = 1'b1
  } back_state_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    cmd_kind_t              kind;
    status_t                status;
    logic [ENTRY_WIDTH-1:0] data;
    logic [ADDR_W-1:0]      addr;
    logic [PEND_W-1:0]      size;
    logic [LEVEL_W-1:0]     level;
  } cmd_t;

  // Ring address plus offset, wrapped at the queue depth (offset <= depth).
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0]  n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(n);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return ADDR_W'(s);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/abrq_front.sv]
// Front end: accepts words, keeps head/count/pending bookkeeping and the
// batch limit, and issues one command per word. Depends on abrq_pkg.
`default_nettype none

module abrq_front
  import abrq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [DATA_W-1:0]  in_data,
  input  wire logic               in_flush,
  input  wire logic               cfg_wen,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output cmd_t                    cmd
);

  logic [LIMIT_W-1:0] limit;
  logic [ADDR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [PEND_W-1:0]  pending, pending_next;

  logic [LIMIT_W-1:0] eff_limit;
  logic [CMP_W-1:0]   ext_cnt, ext_lim, ext_pend, batch_n, ack_n;
  logic               full;
  logic               accept;

  assign accept    = in_valid && cmd_ready;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    if (limit == '0) begin
      eff_limit = LIMIT_W'(1);
    end else if (limit > LIMIT_W'(LIMIT_CAP)) begin
      eff_limit = LIMIT_W'(LIMIT_CAP);
    end else begin
      eff_limit = limit;
    end
  end

  assign ext_cnt  = CMP_W'(count);
  assign ext_lim  = CMP_W'(eff_limit);
  assign ext_pend = CMP_W'(pending);
  assign batch_n  = (ext_cnt < ext_lim) ? ext_cnt : ext_lim;
  assign ack_n    = (ext_pend > ext_cnt) ? ext_cnt : ext_pend;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    head_next    = head;
    count_next   = count;
    pending_next = pending;
    cmd.kind     = CMD_SINGLE;
    cmd.status   = ST_ACK;
    cmd.data     = in_data[ENTRY_WIDTH-1:0];
    cmd.addr     = head;
    cmd.size     = '0;
    case (mode_t'(in_mode))
      MODE_PUSH: begin
        cmd.kind = CMD_PUSH;
        if (full) begin
          // Drop the oldest: its slot takes the new word.
          head_next  = wrap_add(head, CNT_W'(1));
          cmd.status = ST_DROP;
          cmd.addr   = head;
        end else begin
          count_next = count + CNT_W'(1);
          cmd.status = ST_PUSH;
          cmd.addr   = wrap_add(head, count);
        end
      end
      MODE_REQUEST: begin
        if (pending != '0) begin
          cmd.status = ST_BUSY;
        end else if (ext_cnt >= ext_lim || (count != '0 && in_flush)) begin
          cmd.kind     = CMD_BATCH;
          cmd.status   = ST_ENTRY;
          cmd.size     = PEND_W'(batch_n);
          pending_next = PEND_W'(batch_n);
        end else begin
          cmd.status = ST_NONE;
        end
      end
      MODE_ACK: begin
        head_next    = wrap_add(head, CNT_W'(ack_n));
        count_next   = count - CNT_W'(ack_n);
        pending_next = '0;
      end
      MODE_ABORT: begin
        pending_next = '0;
      end
      default: begin
        pending_next = pending;
      end
    endcase
    cmd.level = LEVEL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= LIMIT_RESET;
      head    <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      if (cfg_wen) begin
        limit <= cfg_wdata;
      end
      if (accept) begin
        head    <= head_next;
        count   <= count_next;
        pending <= pending_next;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/abrq_cmd_fifo.sv]
// Short command queue between front and back, so either side can stall.
// Depends on abrq_pkg for the command type and depth.
`default_nettype none

module abrq_cmd_fifo
  import abrq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;
  logic                  do_push, do_pop;

  assign push_ready = (fill != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + FIFO_CNT_W'(1);
        2'b01:   fill <= fill - FIFO_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/abrq_back.sv]
// Back end: owns the entry store, executes commands in order and drives
// the registered result stage. Depends on abrq_pkg.
`default_nettype none

module abrq_back
  import abrq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire cmd_t          cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output status_t            out_status,
  output logic [DATA_W-1:0]  out_data,
  output logic [IDX_W-1:0]   out_index,
  output logic [PEND_W-1:0]  out_size,
  output logic               out_last,
  output logic [LEVEL_W-1:0] out_level
);

  logic [ENTRY_WIDTH-1:0] mem [QUEUE_DEPTH];

  back_state_t            state, state_next;
  logic [ENTRY_WIDTH-1:0] rd_q;
  logic                   rd_valid;
  logic [PEND_W-1:0]      rd_idx, iss_idx;
  logic [ADDR_W-1:0]      rd_addr;
  logic [PEND_W-1:0]      b_size;
  logic [LEVEL_W-1:0]     b_level;

  logic out_free, cmd_take, start_batch, load_single, issue, take_rd, take_last;

  assign out_free  = !out_valid || out_ready;
  assign take_rd   = rd_valid && out_free;
  assign take_last = take_rd && (rd_idx + PEND_W'(1) == b_size);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd_ready && cmd.kind == CMD_BATCH) begin
          state_next = BK_BATCH;
        end
      end
      BK_BATCH: begin
        if (take_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd_ready = 1'b0;
    issue     = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = out_free;
      end
      BK_BATCH: begin
        issue = (iss_idx < b_size) && (!rd_valid || take_rd);
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  assign cmd_take    = cmd_valid && cmd_ready;
  assign start_batch = cmd_take && cmd.kind == CMD_BATCH;
  assign load_single = cmd_take && cmd.kind != CMD_BATCH;

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == CMD_PUSH) begin
      mem[cmd.addr] <= cmd.data;
    end
    if (issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start_batch) begin
      rd_addr <= cmd.addr;
      b_size  <= cmd.size;
      b_level <= cmd.level;
      iss_idx <= '0;
    end else if (issue) begin
      rd_addr <= wrap_add(rd_addr, CNT_W'(1));
      iss_idx <= iss_idx + PEND_W'(1);
    end
    if (issue) begin
      rd_idx <= iss_idx;
    end
    if (load_single) begin
      out_status <= cmd.status;
      out_data   <= '0;
      out_index  <= '0;
      out_size   <= '0;
      out_last   <= 1'b1;
      out_level  <= cmd.level;
    end else if (take_rd) begin
      out_status <= ST_ENTRY;
      out_data   <= DATA_W'(rd_q);
      out_index  <= IDX_W'(rd_idx);
      out_size   <= b_size;
      out_last   <= take_last;
      out_level  <= b_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (take_rd) begin
        rd_valid <= 1'b0;
      end
      if (load_single || take_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_rd_only_in_batch: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == BK_BATCH)
    else $error("read data held outside a batch");

  a_rd_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> rd_idx < b_size)
    else $error("read index beyond batch size");

  a_last_ends_batch: assert property (@(posedge clk) disable iff (rst)
    take_last |=> state == BK_IDLE && !rd_valid)
    else $error("batch did not end after its last entry");

  a_no_cmd_in_batch: assert property (@(posedge clk) disable iff (rst)
    state == BK_BATCH |-> !cmd_ready)
    else $error("command taken while a batch streams");

endmodule

`default_nettype wire

[hw/rtl/ack_batched_ring_queue_unit.sv]
// Top level of the acknowledged batch ring queue.
// Instantiates abrq_front, abrq_cmd_fifo and abrq_back; depends on abrq_pkg.
//
// Usage:
//   s_axis carries one command word: tuser = mode (push, batch request,
//   acknowledge, abort), tdata = entry word and flush-due flag.
//   m_axis returns results: tuser = status, tlast marks the final result of
//   a command, tdata = entry word, batch index, batch size, queue level.
//   cfg_wen/cfg_wdata write the batch limit; write it only while idle.
// Result path and throughput:
//   A single-result command reaches m_axis through the command queue and
//   the result register. A batch request streams its entries one per cycle
//   while m_axis_tready is high; the one read port of the entry store, read
//   once per emitted entry, sets that rate. The front accepts one word per
//   cycle while the four-deep command queue has room, so words keep flowing
//   in while a batch drains.
// Reset (rst, synchronous): queue empty, nothing pending, limit 12. The
//   entry store is not cleared; only pushed entries are ever read.
// Stall: when m_axis_tready is low the result register holds, the back
//   stops, the command queue fills and then s_axis_tready drops.
`default_nettype none

module ack_batched_ring_queue_unit
  import abrq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [63:0] entry_data, [64] flush_due, [71:65] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  wire logic [MODE_W-1:0]      s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [63:0] out_data, [69:64] batch_index, [76:70] batch_size,
  // [85:77] queue_level, [87:86] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]         m_axis_tuser,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_wen,
  input  wire logic [LIMIT_W-1:0]     cfg_wdata
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  status_t            res_status;
  logic [DATA_W-1:0]  res_data;
  logic [IDX_W-1:0]   res_index;
  logic [PEND_W-1:0]  res_size;
  logic [LEVEL_W-1:0] res_level;

  // Classify and update bookkeeping.
  abrq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_data   (s_axis_tdata[DATA_W-1:0]),
    .in_flush  (s_axis_tdata[DATA_W]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple front and back.
  abrq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Execute against the entry store and drive results.
  abrq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (res_status),
    .out_data   (res_data),
    .out_index  (res_index),
    .out_size   (res_size),
    .out_last   (m_axis_tlast),
    .out_level  (res_level)
  );

  // Pack result fields, lowest field first, zero pad to whole bytes.
  assign m_axis_tdata = OUT_TDATA_W'({res_level, res_size, res_index, res_data});
  assign m_axis_tuser = res_status;

endmodule

`default_nettype wire
